### sv/idts_pkg.sv
// Shared types, codes and helpers for the indent/dedent token scanner.
// Depends on nothing; idts_cmp and the top level refer to it by scoped names.
`default_nettype none

package idts_pkg;

  // Default sizes for the top-level parameters
  localparam int STACK_DEPTH_DEF = 16;
  localparam int INDENT_BITS_DEF = 12;

  // Fixed port widths
  localparam int WIDTH_IN_BITS = 12;
  localparam int KIND_BITS     = 3;
  localparam int DEPTH_BITS    = 5;
  localparam int WAIT_BITS     = 5;

  // Token kinds
  localparam logic [KIND_BITS-1:0] TK_NONE     = 3'd0;
  localparam logic [KIND_BITS-1:0] TK_NEWLINE  = 3'd1;
  localparam logic [KIND_BITS-1:0] TK_INDENT   = 3'd2;
  localparam logic [KIND_BITS-1:0] TK_DEDENT   = 3'd3;
  localparam logic [KIND_BITS-1:0] TK_SOFT     = 3'd4;
  localparam logic [KIND_BITS-1:0] TK_SOFT_END = 3'd5;

  // Bit positions in the valid mask
  localparam int VB_NEWLINE  = 0;
  localparam int VB_INDENT   = 1;
  localparam int VB_DEDENT   = 2;
  localparam int VB_SOFT     = 3;
  localparam int VB_SOFT_END = 4;

  // First character class at line start
  localparam logic [2:0] FC_OTHER       = 3'd0;
  localparam logic [2:0] FC_NEWLINE     = 3'd1;
  localparam logic [2:0] FC_COMMENT_NL  = 3'd2;
  localparam logic [2:0] FC_COMMENT_EOF = 3'd3;
  localparam logic [2:0] FC_EOF         = 3'd4;

  // Mid-line character class
  localparam logic [1:0] NC_NEWLINE = 2'd1;
  localparam logic [1:0] NC_EOF     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOP,
    ST_WALK
  } state_t;

  // Result of the shared width comparator
  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_t;

  // Pick the token for a line break from the valid mask
  function automatic logic [KIND_BITS-1:0] line_break(input logic [4:0] valid,
                                                      input logic       closer);
    logic [KIND_BITS-1:0] kind;
    kind = valid[VB_NEWLINE] ? TK_NEWLINE : TK_NONE;
    if (valid[VB_SOFT] || valid[VB_SOFT_END]) begin
      if (closer && valid[VB_SOFT_END]) begin
        kind = TK_SOFT_END;
      end else if (valid[VB_SOFT]) begin
        kind = TK_SOFT;
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

### sv/idts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module idts_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### sv/idts_cmp.sv
// Shared magnitude comparator: request width against one stack entry.
// Depends on idts_pkg for the result struct.
`default_nettype none

module idts_cmp #(
  parameter int INDENT_BITS = idts_pkg::INDENT_BITS_DEF
) (
  input  wire logic [INDENT_BITS-1:0] a,
  input  wire logic [INDENT_BITS-1:0] b,
  output idts_pkg::cmp_t              res
);

  always_comb begin
    res.gt = (a > b);
    res.lt = (a < b);
  end

endmodule

`default_nettype wire

### sv/indent_dedent_token_scanner.sv
// Indent/dedent token scanner: top level, sequencer and state registers.
// Depends on idts_pkg, idts_ram (indent stack) and idts_cmp (shared compare).
// Busy stays high for the top-of-stack compare after accept, and a dedent
// that must count levels goes on to compare the entries below the top one by
// one, bottom entry excluded. The result strobe comes in the cycle in which busy
// drops. No new request is taken while busy, as the single RAM read port feeds
// the one comparator. Reset (sync, active low) leaves one bottom level of width
// 0 and no owed dedents; the receiver cannot stall.
`default_nettype none

module indent_dedent_token_scanner #(
  parameter int STACK_DEPTH = idts_pkg::STACK_DEPTH_DEF,
  parameter int INDENT_BITS = idts_pkg::INDENT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_line_start,
  input  wire logic [idts_pkg::WIDTH_IN_BITS-1:0]  in_indent_width,
  input  wire logic [2:0]                          in_first_class,
  input  wire logic [1:0]                          in_next_class,
  input  wire logic                                in_after_break_class,
  input  wire logic [4:0]                          in_valid_mask,
  // result channel
  output logic                                     out_strobe,
  output logic [idts_pkg::KIND_BITS-1:0]           out_token_kind,
  output logic                                     out_stack_full,
  output logic [idts_pkg::DEPTH_BITS-1:0]          out_depth_now
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int WB = idts_pkg::WIDTH_IN_BITS;
  localparam int DB = idts_pkg::DEPTH_BITS;
  localparam int XB = idts_pkg::WAIT_BITS;
  localparam int KB = idts_pkg::KIND_BITS;

  // Sequencer and stack bookkeeping
  idts_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;   // live stack entries, bottom included
  logic [XB-1:0]    dw_r, dw_nxt;         // dedents still owed
  logic [CW-1:0]    n_r, n_nxt;           // levels counted above the new width
  logic [AW-1:0]    idx_r, idx_nxt;       // entry under compare during the walk

  // Latched request
  logic                   ls_r, ls_nxt;
  logic [INDENT_BITS-1:0] w_r, w_nxt;
  logic [2:0]             fc_r, fc_nxt;
  logic [1:0]             nc_r, nc_nxt;
  logic                   closer_r, closer_nxt;
  logic [4:0]             valid_r, valid_nxt;

  // Result registers
  logic          strobe_r, strobe_nxt;
  logic [KB-1:0] kind_r, kind_nxt;
  logic          full_r, full_nxt;
  logic [DB-1:0] depth_r, depth_nxt;

  // Stack RAM and compare unit hookup
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [INDENT_BITS-1:0] rd_data;
  logic                   wr_en;
  logic [INDENT_BITS-1:0] cmp_b;
  idts_pkg::cmp_t         cmp_res;

  // Width helpers
  logic [INDENT_BITS+WB-1:0] w_ext;
  logic [CW+DB-1:0]          depth_ext;
  logic [CW-1:0]             n_fin;
  logic [CW-1:0]             n_fin_m1;
  logic [CW+XB-1:0]          wait_ext;

  // Only the low INDENT_BITS of the incoming width take part
  assign w_ext     = {{INDENT_BITS{1'b0}}, in_indent_width};
  assign depth_ext = {{DB{1'b0}}, count_nxt};
  assign n_fin_m1  = n_fin - CW'(1);
  assign wait_ext  = {{XB{1'b0}}, n_fin_m1};

  idts_ram #(
    .WIDTH (INDENT_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (w_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  idts_cmp #(
    .INDENT_BITS (INDENT_BITS)
  ) u_cmp (
    .a   (w_r),
    .b   (cmp_b),
    .res (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= idts_pkg::ST_IDLE;
      count_r  <= CW'(1);
      dw_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      dw_r     <= dw_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    idx_r    <= idx_nxt;
    ls_r     <= ls_nxt;
    w_r      <= w_nxt;
    fc_r     <= fc_nxt;
    nc_r     <= nc_nxt;
    closer_r <= closer_nxt;
    valid_r  <= valid_nxt;
    kind_r   <= kind_nxt;
    full_r   <= full_nxt;
    depth_r  <= depth_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    dw_nxt     = dw_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    ls_nxt     = ls_r;
    w_nxt      = w_r;
    fc_nxt     = fc_r;
    nc_nxt     = nc_r;
    closer_nxt = closer_r;
    valid_nxt  = valid_r;
    strobe_nxt = 1'b0;
    kind_nxt   = kind_r;
    full_nxt   = full_r;
    rd_en      = 1'b0;
    rd_addr    = AW'(count_r - CW'(1));
    wr_en      = 1'b0;
    cmp_b      = rd_data;
    n_fin      = n_r;

    case (state_r)
      idts_pkg::ST_IDLE: begin
        // Capture the request and fetch the top of stack
        if (start) begin
          ls_nxt     = in_line_start;
          w_nxt      = w_ext[INDENT_BITS-1:0];
          fc_nxt     = in_first_class;
          nc_nxt     = in_next_class;
          closer_nxt = in_after_break_class;
          valid_nxt  = in_valid_mask;
          rd_en      = 1'b1;
          state_nxt  = idts_pkg::ST_TOP;
        end
      end

      idts_pkg::ST_TOP: begin
        // The bottom entry is never written and always reads as width 0
        if (count_r == CW'(1)) begin
          cmp_b = '0;
        end
        state_nxt  = idts_pkg::ST_IDLE;
        strobe_nxt = 1'b1;
        kind_nxt   = idts_pkg::TK_NONE;
        full_nxt   = 1'b0;

        if (dw_r != '0 && valid_r[idts_pkg::VB_DEDENT]) begin
          // Pay an owed dedent before anything else
          dw_nxt   = dw_r - XB'(1);
          kind_nxt = idts_pkg::TK_DEDENT;
          if (count_r != '0) begin
            count_nxt = count_r - CW'(1);
          end
        end else if (!ls_r) begin
          if (nc_r == idts_pkg::NC_NEWLINE) begin
            kind_nxt = idts_pkg::line_break(valid_r, closer_r);
          end else if (nc_r == idts_pkg::NC_EOF) begin
            if (count_r > CW'(1) && valid_r[idts_pkg::VB_DEDENT]) begin
              count_nxt = count_r - CW'(1);
              kind_nxt  = idts_pkg::TK_DEDENT;
            end
          end
        end else if (fc_r == idts_pkg::FC_NEWLINE || fc_r == idts_pkg::FC_COMMENT_NL) begin
          // Blank or comment-only line; without NEWLINE treat as a mid-line break
          if (valid_r[idts_pkg::VB_NEWLINE]) begin
            kind_nxt = idts_pkg::TK_NEWLINE;
          end else begin
            kind_nxt = idts_pkg::line_break(valid_r, closer_r);
          end
        end else if (fc_r == idts_pkg::FC_COMMENT_EOF || fc_r == idts_pkg::FC_EOF) begin
          // End of input pops one level per request
          if (count_r > CW'(1) && valid_r[idts_pkg::VB_DEDENT]) begin
            count_nxt = count_r - CW'(1);
            kind_nxt  = idts_pkg::TK_DEDENT;
          end
        end else if (fc_r == idts_pkg::FC_OTHER) begin
          if (cmp_res.gt) begin
            if (valid_r[idts_pkg::VB_INDENT]) begin
              kind_nxt = idts_pkg::TK_INDENT;
              // Push when there is room, else drop and flag
              if (count_r < CW'(STACK_DEPTH)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                full_nxt = 1'b1;
              end
            end
          end else if (cmp_res.lt && valid_r[idts_pkg::VB_DEDENT]) begin
            // Top is above the new width: one level counted so far
            if (count_r == CW'(2)) begin
              n_fin     = CW'(1);
              dw_nxt    = wait_ext[XB-1:0];
              count_nxt = count_r - CW'(1);
              kind_nxt  = idts_pkg::TK_DEDENT;
            end else begin
              // Walk down the stack, bottom entry excluded
              n_nxt      = CW'(1);
              idx_nxt    = AW'(count_r - CW'(2));
              rd_en      = 1'b1;
              rd_addr    = AW'(count_r - CW'(2));
              strobe_nxt = 1'b0;
              state_nxt  = idts_pkg::ST_WALK;
            end
          end
        end
      end

      idts_pkg::ST_WALK: begin
        // One stack entry per cycle through the comparator; count entries
        // that sit above the new width
        if (cmp_res.lt && idx_r != AW'(1)) begin
          n_nxt   = n_r + CW'(1);
          idx_nxt = idx_r - AW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(1);
        end else begin
          n_fin      = cmp_res.lt ? (n_r + CW'(1)) : n_r;
          dw_nxt     = wait_ext[XB-1:0];
          count_nxt  = count_r - CW'(1);
          kind_nxt   = idts_pkg::TK_DEDENT;
          full_nxt   = 1'b0;
          strobe_nxt = 1'b1;
          state_nxt  = idts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = idts_pkg::ST_IDLE;
      end
    endcase

    depth_nxt = strobe_nxt ? depth_ext[DB-1:0] : depth_r;
  end

  assign busy           = (state_r != idts_pkg::ST_IDLE);
  assign out_strobe     = strobe_r;
  assign out_token_kind = kind_r;
  assign out_stack_full = full_r;
  assign out_depth_now  = depth_r;

endmodule

`default_nettype wire
